// File: hw/rtl/battery_charge_protection_controller_assert.svh
// Assertion macros used by the protection controller checker bcpc_checker.
// All assertions are clocked on clk_i and held off while rst_ni is low.
`ifndef BATTERY_CHARGE_PROTECTION_CONTROLLER_ASSERT_SVH
`define BATTERY_CHARGE_PROTECTION_CONTROLLER_ASSERT_SVH

// Plain property, same-cycle or overlapping implication inside prop
`define BCPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next
`define BCPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bcpc_pkg.sv
package bcpc_pkg;

  // Raw ADC code and window sum widths
  localparam int unsigned CODE_W = 12;
  localparam int unsigned SUM_W  = 17;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOLT_LOW  = 3'd0,
    CFG_VOLT_HIGH = 3'd1,
    CFG_CHG_TEMP  = 3'd2,
    CFG_DSG_TEMP  = 3'd3,
    CFG_CHG_CURR  = 3'd4,
    CFG_DSG_CURR  = 3'd5
  } cfg_idx_e;

  // Reset codes of the configuration registers
  localparam code_t VOLT_LOW_RST  = 12'd745;
  localparam code_t VOLT_HIGH_RST = 12'd1042;
  localparam code_t CHG_TEMP_RST  = 12'd558;
  localparam code_t DSG_TEMP_RST  = 12'd745;
  localparam code_t CHG_CURR_RST  = 12'd1895;
  localparam code_t DSG_CURR_RST  = 12'd2584;

  // Fault codes
  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_OVER_TEMP = 2'd1,
    FAULT_CHG_OVL   = 2'd2,
    FAULT_DSG_OVL   = 2'd3
  } fault_e;

  // Thresholds, already multiplied by the window length
  typedef struct packed {
    sum_t volt_low;
    sum_t volt_high;
    sum_t chg_temp;
    sum_t dsg_temp;
    sum_t chg_curr;
    sum_t dsg_curr;
  } thr_t;

  // Window sums including the current sample, plus window-end flag
  typedef struct packed {
    sum_t isum;
    sum_t vsum;
    sum_t tsum;
    logic wend;
  } win_t;

  // Decision state after a step
  typedef struct packed {
    logic   charge_on;
    logic   discharge_on;
    logic   mode;
    logic   manual;
    fault_e fault;
  } status_t;

endpackage

// File: hw/rtl/bcpc_sample_if.sv
interface bcpc_sample_if;
  logic             valid;
  logic             ready;
  bcpc_pkg::code_t  current_sample;
  bcpc_pkg::code_t  voltage_sample;
  bcpc_pkg::code_t  temp_sample;
  logic             button_event;

  modport source (
    output valid, current_sample, voltage_sample, temp_sample, button_event,
    input  ready
  );
  modport sink (
    input  valid, current_sample, voltage_sample, temp_sample, button_event,
    output ready
  );
endinterface

// File: hw/rtl/bcpc_result_if.sv
interface bcpc_result_if;
  logic       valid;
  logic       ready;
  logic       charge_switch_on;
  logic       discharge_switch_on;
  logic       discharging_mode;
  logic       manual_mode;
  logic [1:0] fault_code;
  logic       window_end;

  modport source (
    output valid, charge_switch_on, discharge_switch_on, discharging_mode,
           manual_mode, fault_code, window_end,
    input  ready
  );
  modport sink (
    input  valid, charge_switch_on, discharge_switch_on, discharging_mode,
           manual_mode, fault_code, window_end,
    output ready
  );
endinterface

// File: hw/rtl/battery_charge_protection_controller.sv
// Battery charge/discharge protection controller. Each sample transfer carries one
// raw 12-bit current, voltage and temperature code and a debounced button event, and
// produces exactly one result transfer with the switch drives, mode, manual flag,
// fault code and a window-end flag, all showing the state after that sample. Samples
// are summed over SAMPLES_PER_WINDOW transfers (1 to 32) and every threshold compare
// is made on the window sum against the register code times the window length, so
// averages are exact. A new sample can be taken every clock cycle while results are
// taken as they come; each sample waits in the sample register until the result slot
// is free, and its result is then loaded into the result register. While a result
// waits to be taken, one more sample is accepted into the sample register and the
// sample side then stalls until the waiting result transfers. Thresholds must be
// written through the configuration port only while no sample is in flight; the
// block itself does not enforce this. They take effect from the next sample.
module battery_charge_protection_controller #(
  parameter int unsigned SAMPLES_PER_WINDOW = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bcpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  bcpc_pkg::code_t                cfg_wdata_i,
  bcpc_sample_if.sink                    sample_if,
  bcpc_result_if.source                  result_if
);

  logic              s1_valid_d, s1_valid_q;
  bcpc_pkg::code_t   cur_q, volt_q, temp_q;
  logic              btn_q;
  logic              out_valid_d, out_valid_q;
  bcpc_pkg::status_t res_q;
  logic              res_wend_q;

  logic              adv;
  logic              take;
  bcpc_pkg::thr_t    thr;
  bcpc_pkg::win_t    win;
  bcpc_pkg::status_t stat;

  // Pipeline control: the sample stage moves on when the result slot frees up
  assign adv  = s1_valid_q && (!out_valid_q || result_if.ready);
  assign take = sample_if.valid && sample_if.ready;
  assign sample_if.ready = !s1_valid_q || adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (take) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (result_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sample register
  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q  <= sample_if.current_sample;
      volt_q <= sample_if.voltage_sample;
      temp_q <= sample_if.temp_sample;
      btn_q  <= sample_if.button_event;
    end
  end

  bcpc_cfg_regs #(
    .SAMPLES_PER_WINDOW (SAMPLES_PER_WINDOW)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .thr_o       (thr)
  );

  bcpc_accum #(
    .SAMPLES_PER_WINDOW (SAMPLES_PER_WINDOW)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .current_i (cur_q),
    .voltage_i (volt_q),
    .temp_i    (temp_q),
    .win_o     (win)
  );

  bcpc_decide u_decide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .button_i (btn_q),
    .win_i    (win),
    .thr_i    (thr),
    .stat_o   (stat)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q      <= stat;
      res_wend_q <= win.wend;
    end
  end

  assign result_if.valid               = out_valid_q;
  assign result_if.charge_switch_on    = res_q.charge_on;
  assign result_if.discharge_switch_on = res_q.discharge_on;
  assign result_if.discharging_mode    = res_q.mode;
  assign result_if.manual_mode         = res_q.manual;
  assign result_if.fault_code          = res_q.fault;
  assign result_if.window_end          = res_wend_q;

endmodule

// File: hw/rtl/bcpc_cfg_regs.sv
module bcpc_cfg_regs #(
  parameter int unsigned SAMPLES_PER_WINDOW = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bcpc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  bcpc_pkg::code_t                    cfg_wdata_i,
  output bcpc_pkg::thr_t                     thr_o
);

  // Window length as a sum-wide multiplier
  localparam bcpc_pkg::sum_t NScale = bcpc_pkg::SUM_W'(SAMPLES_PER_WINDOW);

  localparam bcpc_pkg::sum_t VoltLowRst  = bcpc_pkg::sum_t'(bcpc_pkg::VOLT_LOW_RST) * NScale;
  localparam bcpc_pkg::sum_t VoltHighRst = bcpc_pkg::sum_t'(bcpc_pkg::VOLT_HIGH_RST) * NScale;
  localparam bcpc_pkg::sum_t ChgTempRst  = bcpc_pkg::sum_t'(bcpc_pkg::CHG_TEMP_RST) * NScale;
  localparam bcpc_pkg::sum_t DsgTempRst  = bcpc_pkg::sum_t'(bcpc_pkg::DSG_TEMP_RST) * NScale;
  localparam bcpc_pkg::sum_t ChgCurrRst  = bcpc_pkg::sum_t'(bcpc_pkg::CHG_CURR_RST) * NScale;
  localparam bcpc_pkg::sum_t DsgCurrRst  = bcpc_pkg::sum_t'(bcpc_pkg::DSG_CURR_RST) * NScale;

  bcpc_pkg::thr_t thr_d, thr_q;
  bcpc_pkg::sum_t scaled;

  // Codes are stored pre-multiplied so the window sum compares directly
  assign scaled = bcpc_pkg::sum_t'(cfg_wdata_i) * NScale;

  always_comb begin
    thr_d = thr_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        bcpc_pkg::CFG_VOLT_LOW:  thr_d.volt_low  = scaled;
        bcpc_pkg::CFG_VOLT_HIGH: thr_d.volt_high = scaled;
        bcpc_pkg::CFG_CHG_TEMP:  thr_d.chg_temp  = scaled;
        bcpc_pkg::CFG_DSG_TEMP:  thr_d.dsg_temp  = scaled;
        bcpc_pkg::CFG_CHG_CURR:  thr_d.chg_curr  = scaled;
        bcpc_pkg::CFG_DSG_CURR:  thr_d.dsg_curr  = scaled;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.volt_low  <= VoltLowRst;
      thr_q.volt_high <= VoltHighRst;
      thr_q.chg_temp  <= ChgTempRst;
      thr_q.dsg_temp  <= DsgTempRst;
      thr_q.chg_curr  <= ChgCurrRst;
      thr_q.dsg_curr  <= DsgCurrRst;
    end else begin
      thr_q <= thr_d;
    end
  end

  assign thr_o = thr_q;

endmodule

// File: hw/rtl/bcpc_accum.sv
module bcpc_accum #(
  parameter int unsigned SAMPLES_PER_WINDOW = 20
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  bcpc_pkg::code_t current_i,
  input  bcpc_pkg::code_t voltage_i,
  input  bcpc_pkg::code_t temp_i,
  output bcpc_pkg::win_t  win_o
);

  localparam bcpc_pkg::cnt_t LastCnt = bcpc_pkg::CNT_W'(SAMPLES_PER_WINDOW - 1);

  bcpc_pkg::sum_t isum_d, isum_q;
  bcpc_pkg::sum_t vsum_d, vsum_q;
  bcpc_pkg::sum_t tsum_d, tsum_q;
  bcpc_pkg::cnt_t cnt_d, cnt_q;
  bcpc_pkg::win_t win;

  // Sums including this sample; these are what the window end evaluates
  always_comb begin
    win.isum = isum_q + bcpc_pkg::sum_t'(current_i);
    win.vsum = vsum_q + bcpc_pkg::sum_t'(voltage_i);
    win.tsum = tsum_q + bcpc_pkg::sum_t'(temp_i);
    win.wend = (cnt_q >= LastCnt);
  end

  // Restart the window after its last sample
  always_comb begin
    isum_d = isum_q;
    vsum_d = vsum_q;
    tsum_d = tsum_q;
    cnt_d  = cnt_q;
    if (en_i) begin
      if (win.wend) begin
        isum_d = '0;
        vsum_d = '0;
        tsum_d = '0;
        cnt_d  = '0;
      end else begin
        isum_d = win.isum;
        vsum_d = win.vsum;
        tsum_d = win.tsum;
        cnt_d  = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      isum_q <= '0;
      vsum_q <= '0;
      tsum_q <= '0;
      cnt_q  <= '0;
    end else begin
      isum_q <= isum_d;
      vsum_q <= vsum_d;
      tsum_q <= tsum_d;
      cnt_q  <= cnt_d;
    end
  end

  assign win_o = win;

endmodule

// File: hw/rtl/bcpc_decide.sv
module bcpc_decide (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                button_i,
  input  bcpc_pkg::win_t      win_i,
  input  bcpc_pkg::thr_t      thr_i,
  output bcpc_pkg::status_t   stat_o
);

  logic            mode_d, mode_q;
  logic            manual_d, manual_q;
  logic            pend_d, pend_q;
  bcpc_pkg::fault_e fault_d, fault_q;

  logic            mode_w;
  logic            manual_w;
  bcpc_pkg::fault_e fault_b;
  logic            pend_b;
  logic            ovt;
  logic            ovl;

  always_comb begin
    // Button first: clears an overload, or is held until the window end
    fault_b = fault_q;
    pend_b  = pend_q;
    if (button_i) begin
      if (fault_q == bcpc_pkg::FAULT_CHG_OVL || fault_q == bcpc_pkg::FAULT_DSG_OVL) begin
        fault_b = bcpc_pkg::FAULT_NONE;
      end else if (fault_q == bcpc_pkg::FAULT_NONE) begin
        pend_b = 1'b1;
      end
    end

    // Mode and manual after the press toggle and voltage hysteresis
    mode_w   = mode_q;
    manual_w = manual_q;
    if (fault_b == bcpc_pkg::FAULT_NONE) begin
      if (pend_b) begin
        mode_w   = ~mode_q;
        manual_w = ~manual_q;
      end
      if (!manual_w) begin
        if (win_i.vsum < thr_i.volt_low) begin
          mode_w = 1'b0;
        end else if (win_i.vsum >= thr_i.volt_high) begin
          mode_w = 1'b1;
        end
      end
    end

    // Limits of the mode in force
    ovt = win_i.tsum > (mode_w ? thr_i.dsg_temp : thr_i.chg_temp);
    ovl = win_i.isum > (mode_w ? thr_i.dsg_curr : thr_i.chg_curr);

    mode_d   = mode_q;
    manual_d = manual_q;
    fault_d  = fault_q;
    pend_d   = pend_q;
    if (en_i) begin
      fault_d = fault_b;
      pend_d  = pend_b;
      if (win_i.wend) begin
        pend_d = 1'b0;
        case (fault_b)
          bcpc_pkg::FAULT_NONE, bcpc_pkg::FAULT_OVER_TEMP: begin
            mode_d   = mode_w;
            manual_d = manual_w;
            if (ovt) begin
              fault_d = bcpc_pkg::FAULT_OVER_TEMP;
            end else if (ovl) begin
              fault_d = mode_w ? bcpc_pkg::FAULT_DSG_OVL : bcpc_pkg::FAULT_CHG_OVL;
            end else begin
              fault_d = bcpc_pkg::FAULT_NONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      manual_q <= 1'b0;
      pend_q   <= 1'b0;
      fault_q  <= bcpc_pkg::FAULT_NONE;
    end else begin
      mode_q   <= mode_d;
      manual_q <= manual_d;
      pend_q   <= pend_d;
      fault_q  <= fault_d;
    end
  end

  // State after this step, for the result register
  always_comb begin
    stat_o.mode         = mode_d;
    stat_o.manual       = manual_d;
    stat_o.fault        = fault_d;
    stat_o.charge_on    = (fault_d == bcpc_pkg::FAULT_NONE) && !mode_d;
    stat_o.discharge_on = (fault_d == bcpc_pkg::FAULT_NONE) && mode_d;
  end

endmodule

// File: hw/rtl/bcpc_checker.sv
`include "battery_charge_protection_controller_assert.svh"

module bcpc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       charge_on_i,
  input logic       discharge_on_i,
  input logic       mode_i,
  input logic       manual_i,
  input logic [1:0] fault_i,
  input logic       wend_i
);

  // Both switches must never conduct together
  `BCPC_ASSERT(a_switch_excl, out_valid_i |-> !(charge_on_i && discharge_on_i), "both switches on")

  // Any fault opens both switches
  `BCPC_ASSERT(a_fault_off, (out_valid_i && fault_i != bcpc_pkg::FAULT_NONE) |-> (!charge_on_i && !discharge_on_i), "switch on during fault")

  // Without a fault, exactly the switch of the current mode conducts
  `BCPC_ASSERT(a_mode_switch, (out_valid_i && fault_i == bcpc_pkg::FAULT_NONE) |-> (charge_on_i == !mode_i && discharge_on_i == mode_i), "switch does not follow mode")

  // A stalled result holds
  `BCPC_ASSERT_NEXT(a_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(charge_on_i) && $stable(discharge_on_i) && $stable(mode_i) && $stable(manual_i) && $stable(fault_i) && $stable(wend_i), "stalled result changed")

endmodule

bind battery_charge_protection_controller bcpc_checker u_bcpc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (result_if.valid),
  .out_ready_i    (result_if.ready),
  .charge_on_i    (result_if.charge_switch_on),
  .discharge_on_i (result_if.discharge_switch_on),
  .mode_i         (result_if.discharging_mode),
  .manual_i       (result_if.manual_mode),
  .fault_i        (result_if.fault_code),
  .wend_i         (result_if.window_end)
);

// File: verif/battery_charge_protection_controller_checker.sv
// Watches the sample and result channels, keeps its own copy of the protection
// state and thresholds, and compares every result transfer with the oldest prediction.
module battery_charge_protection_controller_checker
  import bcpc_pkg::*;
#(
  parameter int unsigned WIN = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  code_t                 cfg_wdata_i,
  bcpc_sample_if                sample_if,
  bcpc_result_if                result_if,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  typedef struct packed {
    status_t status;
    logic    wend;
  } outcome_t;

  // Threshold copy, indexed by register
  code_t       thr_code [6];

  // Protection state
  sum_t        i_acc, v_acc, t_acc;
  cnt_t        fill_count;
  logic        discharging, manual_on, press_seen;
  fault_e      fault_now;

  outcome_t    expected_status_q [$];
  int unsigned mismatches = 0;
  int unsigned outstanding = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  // Register code scaled to a window sum; never wraps
  function automatic int unsigned window_limit(code_t code);
    return 32'(code) * WIN;
  endfunction

  function automatic bit temp_exceeded(sum_t tsum);
    return tsum > window_limit(discharging ? thr_code[CFG_DSG_TEMP] : thr_code[CFG_CHG_TEMP]);
  endfunction

  // Overload verdict for the present mode
  function automatic fault_e current_fault(sum_t isum);
    if (discharging) begin
      return (isum > window_limit(thr_code[CFG_DSG_CURR])) ? FAULT_DSG_OVL : FAULT_NONE;
    end
    return (isum > window_limit(thr_code[CFG_CHG_CURR])) ? FAULT_CHG_OVL : FAULT_NONE;
  endfunction

  task automatic flag_mismatch(input string field, input logic [1:0] want_v,
                               input logic [1:0] got_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    logic     closed;
    if (!rst_ni) begin
      thr_code[CFG_VOLT_LOW]  = VOLT_LOW_RST;
      thr_code[CFG_VOLT_HIGH] = VOLT_HIGH_RST;
      thr_code[CFG_CHG_TEMP]  = CHG_TEMP_RST;
      thr_code[CFG_DSG_TEMP]  = DSG_TEMP_RST;
      thr_code[CFG_CHG_CURR]  = CHG_CURR_RST;
      thr_code[CFG_DSG_CURR]  = DSG_CURR_RST;
      i_acc       = '0;
      v_acc       = '0;
      t_acc       = '0;
      fill_count  = '0;
      discharging = 1'b0;
      manual_on   = 1'b0;
      press_seen  = 1'b0;
      fault_now   = FAULT_NONE;
      expected_status_q.delete();
      outstanding = 0;
    end else begin
      // Register writes; unused indexes are dropped
      if (cfg_we_i && cfg_idx_i <= CFG_DSG_CURR) begin
        thr_code[cfg_idx_i] = cfg_wdata_i;
      end

      // Result transfer: compare against the oldest prediction
      if (result_if.valid && result_if.ready) begin
        if (expected_status_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected", $time);
          mismatches++;
        end else begin
          want = expected_status_q.pop_front();
          if (result_if.charge_switch_on !== want.status.charge_on)
            flag_mismatch("charge_switch_on", want.status.charge_on,
                          result_if.charge_switch_on);
          if (result_if.discharge_switch_on !== want.status.discharge_on)
            flag_mismatch("discharge_switch_on", want.status.discharge_on,
                          result_if.discharge_switch_on);
          if (result_if.discharging_mode !== want.status.mode)
            flag_mismatch("discharging_mode", want.status.mode, result_if.discharging_mode);
          if (result_if.manual_mode !== want.status.manual)
            flag_mismatch("manual_mode", want.status.manual, result_if.manual_mode);
          if (result_if.fault_code !== want.status.fault)
            flag_mismatch("fault_code", want.status.fault, result_if.fault_code);
          if (result_if.window_end !== want.wend)
            flag_mismatch("window_end", want.wend, result_if.window_end);
        end
      end

      // Sample transfer: advance the state and queue what it should produce
      if (sample_if.valid && sample_if.ready) begin
        // Button clears an overload at once, is ignored in over-temp
        if (sample_if.button_event) begin
          if (fault_now == FAULT_CHG_OVL || fault_now == FAULT_DSG_OVL) begin
            fault_now = FAULT_NONE;
          end else if (fault_now == FAULT_NONE) begin
            press_seen = 1'b1;
          end
        end

        i_acc = i_acc + sample_if.current_sample;
        v_acc = v_acc + sample_if.voltage_sample;
        t_acc = t_acc + sample_if.temp_sample;

        if (fill_count + 1 >= WIN) begin
          // Window closed: decisions on the full sums
          case (fault_now)
            FAULT_OVER_TEMP: begin
              if (!temp_exceeded(t_acc)) fault_now = current_fault(i_acc);
            end
            FAULT_NONE: begin
              if (press_seen) begin
                manual_on   = ~manual_on;
                discharging = ~discharging;
              end
              // Voltage hysteresis in auto mode only
              if (!manual_on) begin
                if (v_acc < window_limit(thr_code[CFG_VOLT_LOW])) begin
                  discharging = 1'b0;
                end else if (v_acc >= window_limit(thr_code[CFG_VOLT_HIGH])) begin
                  discharging = 1'b1;
                end
              end
              if (temp_exceeded(t_acc)) fault_now = FAULT_OVER_TEMP;
              else fault_now = current_fault(i_acc);
            end
            default: ;  // overload holds everything
          endcase
          press_seen = 1'b0;
          i_acc      = '0;
          v_acc      = '0;
          t_acc      = '0;
          fill_count = '0;
          closed     = 1'b1;
        end else begin
          fill_count = fill_count + 1'b1;
          closed     = 1'b0;
        end

        want.status.charge_on    = (fault_now == FAULT_NONE) && !discharging;
        want.status.discharge_on = (fault_now == FAULT_NONE) && discharging;
        want.status.mode         = discharging;
        want.status.manual       = manual_on;
        want.status.fault        = fault_now;
        want.wend                = closed;
        expected_status_q.push_back(want);
      end
      outstanding = expected_status_q.size();
    end
  end

endmodule

// File: verif/battery_charge_protection_controller_tb.sv
module battery_charge_protection_controller_tb;
  import bcpc_pkg::*;

  localparam int unsigned WIN         = 20;
  localparam int unsigned PHASE_ITEMS = 185;
  localparam int unsigned HOLD_CYCLES = 300;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  code_t                cfg_wdata_i;

  bcpc_sample_if sample_if ();
  bcpc_result_if result_if ();

  int unsigned fail_count;
  int unsigned pending_count;

  // Idle percentages of both sides and the one-off long hold
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  logic        hold_req;

  // Thresholds as last written, used to aim windows near them
  code_t       limit_shadow [6];
  int unsigned items_sent;
  code_t       aim_curr, aim_volt, aim_temp;
  int unsigned jitter;
  bit          noise_window;

  battery_charge_protection_controller #(
    .SAMPLES_PER_WINDOW (WIN)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_if   (sample_if),
    .result_if   (result_if)
  );

  battery_charge_protection_controller_checker #(
    .WIN (WIN)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_if    (sample_if),
    .result_if    (result_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("** battery_charge_protection_controller: FAILED **");
    $finish;
  end

  // Result side: random back-pressure plus one long hold
  initial begin
    int unsigned hold_left;
    bit          hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  function automatic code_t clamp_code(int x);
    if (x < 0) return '0;
    if (x > 4095) return 12'd4095;
    return code_t'(x);
  endfunction

  // Window aim: mostly near one of two thresholds, sometimes an extreme or a random code
  function automatic code_t pick_aim(code_t a, code_t b);
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 4) return clamp_code(int'(a) + int'($urandom_range(4)) - 2);
    if (sel < 7) return clamp_code(int'(b) + int'($urandom_range(4)) - 2);
    if (sel == 7) return '0;
    if (sel == 8) return 12'd4095;
    return code_t'($urandom_range(4095));
  endfunction

  function automatic code_t near(code_t aim);
    return clamp_code(int'(aim) + int'($urandom_range(2 * jitter)) - int'(jitter));
  endfunction

  // One sample transfer, with random gaps in front of it
  task automatic send_sample(input code_t c, input code_t v, input code_t t, input logic b);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid          <= 1'b1;
    sample_if.current_sample <= c;
    sample_if.voltage_sample <= v;
    sample_if.temp_sample    <= t;
    sample_if.button_event   <= b;
    do @(posedge clk_i); while (!sample_if.ready);
    items_sent++;
  endtask

  // Random sample: windows aimed at the thresholds, a few pure-noise windows
  task automatic send_random_item();
    if (items_sent % WIN == 0) begin
      noise_window = ($urandom_range(9) == 0);
      aim_curr = pick_aim(limit_shadow[CFG_CHG_CURR], limit_shadow[CFG_DSG_CURR]);
      aim_volt = pick_aim(limit_shadow[CFG_VOLT_LOW], limit_shadow[CFG_VOLT_HIGH]);
      aim_temp = pick_aim(limit_shadow[CFG_CHG_TEMP], limit_shadow[CFG_DSG_TEMP]);
      case ($urandom_range(2))
        0:       jitter = 0;
        1:       jitter = 2;
        default: jitter = 60;
      endcase
    end
    if (noise_window) begin
      send_sample(code_t'($urandom_range(4095)), code_t'($urandom_range(4095)),
                  code_t'($urandom_range(4095)), $urandom_range(7) == 0);
    end else begin
      send_sample(near(aim_curr), near(aim_volt), near(aim_temp), $urandom_range(29) == 0);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input code_t val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    limit_shadow[idx] = val;
    @(posedge clk_i);
  endtask

  // Drain the block, then rewrite all six thresholds
  task automatic apply_thresholds(input code_t vl, input code_t vh, input code_t ct,
                                  input code_t dt, input code_t cc, input code_t dc);
    sample_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending_count == 0);
    repeat (4) @(posedge clk_i);
    write_reg(CFG_VOLT_LOW, vl);
    write_reg(CFG_VOLT_HIGH, vh);
    write_reg(CFG_CHG_TEMP, ct);
    write_reg(CFG_DSG_TEMP, dt);
    write_reg(CFG_CHG_CURR, cc);
    write_reg(CFG_DSG_CURR, dc);
    cfg_we_i <= 1'b0;
  endtask

  // Stimulus and verdict
  initial begin
    code_t vl;
    rst_ni                   = 1'b0;
    cfg_we_i                 = 1'b0;
    cfg_idx_i                = CFG_VOLT_LOW;
    cfg_wdata_i              = '0;
    sample_if.valid          = 1'b0;
    sample_if.current_sample = '0;
    sample_if.voltage_sample = '0;
    sample_if.temp_sample    = '0;
    sample_if.button_event   = 1'b0;
    hold_req                 = 1'b0;
    src_idle_pct             = 31;
    sink_idle_pct            = 80;
    items_sent               = 0;
    jitter                   = 0;
    noise_window             = 1'b0;
    aim_curr                 = '0;
    aim_volt                 = '0;
    aim_temp                 = '0;
    limit_shadow[CFG_VOLT_LOW]  = VOLT_LOW_RST;
    limit_shadow[CFG_VOLT_HIGH] = VOLT_HIGH_RST;
    limit_shadow[CFG_CHG_TEMP]  = CHG_TEMP_RST;
    limit_shadow[CFG_DSG_TEMP]  = DSG_TEMP_RST;
    limit_shadow[CFG_CHG_CURR]  = CHG_CURR_RST;
    limit_shadow[CFG_DSG_CURR]  = DSG_CURR_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed window: all-zero sample, then full-scale current with a press
    // early on, so the window toggles into manual discharging and trips overload
    send_sample('0, '0, '0, 1'b0);
    for (int k = 1; k < WIN; k++) begin
      send_sample(12'd4095, (k % 2 == 1) ? 12'd4095 : 12'd0, (k == 5) ? 12'd4095 : 12'd0,
                  k == 3);
    end
    // Press during overload clears it; the next press is only remembered
    send_sample(12'd0, 12'd0, 12'd0, 1'b1);
    send_sample(12'd0, 12'd0, 12'd0, 1'b1);
    repeat (3) send_sample(12'd4095, 12'd4095, 12'd4095, 1'b1);

    // Random phases over several threshold settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin
          apply_thresholds(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
          src_idle_pct  = 80;
          sink_idle_pct = 31;
        end
        2: begin
          apply_thresholds('0, '0, '0, '0, '0, '0);
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
        3: begin
          apply_thresholds(code_t'($urandom_range(4095)), code_t'($urandom_range(4095)),
                           code_t'($urandom_range(4095)), code_t'($urandom_range(4095)),
                           code_t'($urandom_range(4095)), code_t'($urandom_range(4095)));
        end
        4: begin
          vl = code_t'($urandom_range(500, 1500));
          apply_thresholds(vl, vl + code_t'($urandom_range(800)),
                           code_t'($urandom_range(300, 1500)),
                           code_t'($urandom_range(300, 1500)),
                           code_t'($urandom_range(1500, 3000)),
                           code_t'($urandom_range(1500, 3000)));
        end
        default: ;
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Long result-side hold while samples keep coming
        if (ph == 0 && k == 60) hold_req <= 1'b1;
        send_random_item();
      end
    end

    sample_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending_count == 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** battery_charge_protection_controller: PASSED **");
    end else begin
      $display("** battery_charge_protection_controller: FAILED **");
    end
    $finish;
  end

endmodule

// File: battery_charge_protection_controller.f
+incdir+hw/rtl
hw/rtl/bcpc_pkg.sv
hw/rtl/bcpc_sample_if.sv
hw/rtl/bcpc_result_if.sv
hw/rtl/bcpc_cfg_regs.sv
hw/rtl/bcpc_accum.sv
hw/rtl/bcpc_decide.sv
hw/rtl/battery_charge_protection_controller.sv
hw/rtl/bcpc_checker.sv
verif/battery_charge_protection_controller_checker.sv
verif/battery_charge_protection_controller_tb.sv
